FILE: sv/sceq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted countdown expiry queue package
// Shared word formats, result codes and sequencer states of the expiry queue.
// ----------------------------------------------------------------------------
package sceq_pkg;

    localparam int DEF_QUEUE_CAPACITY = 16;

    typedef enum logic
    {
        ACT_INSERT = 1'b0,
        ACT_TICK   = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        KIND_ACCEPTED = 2'd0,
        KIND_FULL     = 2'd1,
        KIND_EXPIRED  = 2'd2
    } kind_t;

    // Command word taken at the input handshake.
    typedef struct packed
    {
        action_t     action;
        logic [15:0] user_id;
        logic [15:0] duration;
    } cmd_t;

    // Result word shown for one cycle under the strobe.
    typedef struct packed
    {
        kind_t       kind;
        logic [15:0] expired_id;
        logic [15:0] expired_cost;
        logic        last;
        logic [4:0]  occupancy;
    } result_t;

    // One queue entry as held in the entry memory. The deadline is an
    // absolute time stamp; the remaining count is deadline minus the time base.
    typedef struct packed
    {
        logic [15:0] user_id;
        logic [15:0] deadline;
        logic [15:0] cost;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SHIFT,
        S_PLACE,
        S_SCAN,
        S_EMIT
    } state_t;

endpackage

FILE: sv/sceq_ram.sv
// ----------------------------------------------------------------------------
// Expiry queue entry RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module sceq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/sorted_countdown_expiry_queue.sv
// ----------------------------------------------------------------------------
// Sorted countdown expiry queue
// Bounded timeout list kept in ascending order of remaining count, with
// insert and tick commands and at most one result word per cycle on a strobe.
// ----------------------------------------------------------------------------
// A refused insert, or an insert into an empty queue, answers in the cycle
// after it is taken. Any other accepted insert stays busy while it moves up
// each entry that it passes and writes the new one, and answers next.
// A tick that expires n entries scans min(n+1, occupancy) entries, then shows
// n result words on consecutive cycles; with nothing expired it gives none.
// One command is taken at a time; busy holds off the next until idle.
// Reset clears the sequencer, the strobe, the entry count, the head pointer
// and the time base; the entry RAM and the data registers are left as they are.
// ----------------------------------------------------------------------------
module sorted_countdown_expiry_queue #(
    parameter int QUEUE_CAPACITY = sceq_pkg::DEF_QUEUE_CAPACITY
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sceq_pkg::cmd_t    cmd,
    output logic              strobe,
    output sceq_pkg::result_t result
);

    import sceq_pkg::*;

    // AW addresses the RAM; CW holds a count from zero up to the capacity.
    localparam int AW = $clog2(QUEUE_CAPACITY);
    localparam int CW = $clog2(QUEUE_CAPACITY + 1);

    // An entry expires on a tick when its remaining count is below this.
    localparam logic [15:0] EXPIRE_LIMIT = 16'd2;

    state_t        state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] total_reg, total_next;
    logic [15:0]   now_reg, now_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] nexp_reg, nexp_next;
    cmd_t          cmd_reg, cmd_next;
    result_t       result_reg, result_next;
    logic          strobe_reg, strobe_next;

    logic               accept;
    logic               is_full;
    cmd_t               ins_src;
    entry_t             new_entry;
    entry_t             rd_entry;
    entry_t             wr_entry;
    logic [ENTRY_W-1:0] rd_word;
    logic               rd_en;
    logic [CW-1:0]      rd_idx;
    logic               wr_en;
    logic [CW-1:0]      wr_idx;
    logic [15:0]        rem;
    logic [15:0]        cmp_b;
    logic               ge;
    logic               expired;
    logic [CW-1:0]      idx_inc;
    logic [CW-1:0]      n_scan;

    // Logical queue position to RAM slot: the queue is a ring that starts at
    // the head pointer, so removing expired entries only moves the head.
    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(QUEUE_CAPACITY))
        begin
            s = s - (CW+1)'(QUEUE_CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    // The occupancy field is five bits wide whatever the capacity.
    function automatic logic [4:0] occ5(input logic [CW-1:0] c);
        logic [CW+4:0] t;
        t = (CW+5)'(c);
        return t[4:0];
    endfunction

    assign accept  = start && !busy;
    assign is_full = total_reg >= CW'(QUEUE_CAPACITY);

    // The new entry comes straight from the port when it is written in the
    // accepting cycle, and from the held command otherwise.
    assign ins_src             = (state_reg == S_IDLE) ? cmd : cmd_reg;
    assign new_entry.user_id   = ins_src.user_id;
    assign new_entry.deadline  = now_reg + ins_src.duration;
    assign new_entry.cost      = ins_src.duration;

    // Shared compare unit. The remaining count of the entry just read is its
    // deadline minus the time base. An insert walk moves entries whose count
    // is at least the new duration; a tick scan stops at the first entry that
    // still has two or more ticks to go.
    assign rd_entry = entry_t'(rd_word);
    assign rem      = rd_entry.deadline - now_reg;
    assign cmp_b    = (state_reg == S_SCAN) ? EXPIRE_LIMIT : cmd_reg.duration;
    assign ge       = rem >= cmp_b;
    assign expired  = !ge;

    assign idx_inc = idx_reg + CW'(1);
    assign n_scan  = expired ? idx_inc : idx_reg;

    sceq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_CAPACITY)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wrap(head_reg, wr_idx)),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (wrap(head_reg, rd_idx)),
        .rd_data (rd_word)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.action == ACT_INSERT)
                    begin
                        if (!is_full && (total_reg != '0))
                        begin
                            state_next = S_SHIFT;
                        end
                    end
                    else if (total_reg != '0)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SHIFT:
            begin
                if (!ge)
                begin
                    state_next = S_IDLE;
                end
                else if (idx_reg == CW'(1))
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (!(expired && (idx_inc != total_reg)))
                begin
                    state_next = (n_scan == '0) ? S_IDLE : S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (idx_inc == nexp_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs: RAM control, working registers and the result word.
    always_comb
    begin
        head_next   = head_reg;
        total_next  = total_reg;
        now_next    = now_reg;
        idx_next    = idx_reg;
        nexp_next   = nexp_reg;
        cmd_next    = cmd_reg;
        result_next = result_reg;
        strobe_next = 1'b0;
        rd_en       = 1'b0;
        rd_idx      = '0;
        wr_en       = 1'b0;
        wr_idx      = idx_reg;
        wr_entry    = new_entry;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd;
                    if (cmd.action == ACT_INSERT)
                    begin
                        if (is_full)
                        begin
                            result_next = '{kind: KIND_FULL, expired_id: '0,
                                            expired_cost: '0, last: 1'b1,
                                            occupancy: occ5(total_reg)};
                            strobe_next = 1'b1;
                        end
                        else if (total_reg == '0)
                        begin
                            // Empty queue: the entry goes straight to the head.
                            wr_en       = 1'b1;
                            wr_idx      = '0;
                            total_next  = total_reg + CW'(1);
                            result_next = '{kind: KIND_ACCEPTED, expired_id: '0,
                                            expired_cost: '0, last: 1'b1,
                                            occupancy: occ5(total_reg + CW'(1))};
                            strobe_next = 1'b1;
                        end
                        else
                        begin
                            // Walk down from the tail, one entry per cycle.
                            rd_en    = 1'b1;
                            rd_idx   = total_reg - CW'(1);
                            idx_next = total_reg;
                        end
                    end
                    else if (total_reg != '0)
                    begin
                        rd_en    = 1'b1;
                        rd_idx   = '0;
                        idx_next = '0;
                    end
                end
            end
            S_SHIFT:
            begin
                // The read data holds queue position idx-1.
                if (ge)
                begin
                    wr_en    = 1'b1;
                    wr_entry = rd_entry;
                    idx_next = idx_reg - CW'(1);
                    if (idx_reg != CW'(1))
                    begin
                        rd_en  = 1'b1;
                        rd_idx = idx_reg - CW'(2);
                    end
                end
                else
                begin
                    wr_en       = 1'b1;
                    total_next  = total_reg + CW'(1);
                    result_next = '{kind: KIND_ACCEPTED, expired_id: '0,
                                    expired_cost: '0, last: 1'b1,
                                    occupancy: occ5(total_reg + CW'(1))};
                    strobe_next = 1'b1;
                end
            end
            S_PLACE:
            begin
                // Every entry moved up, so the new one takes the head.
                wr_en       = 1'b1;
                total_next  = total_reg + CW'(1);
                result_next = '{kind: KIND_ACCEPTED, expired_id: '0,
                                expired_cost: '0, last: 1'b1,
                                occupancy: occ5(total_reg + CW'(1))};
                strobe_next = 1'b1;
            end
            S_SCAN:
            begin
                // Count the leading entries that run out on this tick. The
                // occupancy on every result word needs that count first.
                if (expired && (idx_inc != total_reg))
                begin
                    rd_en    = 1'b1;
                    rd_idx   = idx_inc;
                    idx_next = idx_inc;
                end
                else
                begin
                    now_next  = now_reg + 16'd1;
                    nexp_next = n_scan;
                    idx_next  = '0;
                    if (n_scan != '0)
                    begin
                        rd_en  = 1'b1;
                        rd_idx = '0;
                    end
                end
            end
            S_EMIT:
            begin
                result_next = '{kind: KIND_EXPIRED,
                                expired_id: rd_entry.user_id,
                                expired_cost: rd_entry.cost,
                                last: (idx_inc == nexp_reg),
                                occupancy: occ5(total_reg - nexp_reg)};
                strobe_next = 1'b1;
                if (idx_inc == nexp_reg)
                begin
                    head_next  = wrap(head_reg, nexp_reg);
                    total_next = total_reg - nexp_reg;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_idx   = idx_inc;
                    idx_next = idx_inc;
                end
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            total_reg  <= '0;
            now_reg    <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            total_reg  <= total_next;
            now_reg    <= now_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nexp_reg   <= nexp_next;
        cmd_reg    <= cmd_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    // The entry count never passes the capacity.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CW'(QUEUE_CAPACITY))
    else $error("entry count above capacity");

    // The ring head always points at a real RAM slot.
    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(head_reg) < QUEUE_CAPACITY)
    else $error("head pointer out of range");

    // An insert answer is always the only word of its command.
    a_insert_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.kind != KIND_EXPIRED) |-> result.last)
    else $error("insert answer without last flag");

    // An expired word that is not last is followed at once by another one.
    a_expire_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.kind == KIND_EXPIRED) && !result.last
        |=> strobe && (result.kind == KIND_EXPIRED))
    else $error("expiry run broken");

endmodule
